// File: src/ddpi_pkg.sv
// ----------------------------------------------------------------------------
// ddpi_pkg
// Shared constants, types and helpers for the pose integrator.
// ----------------------------------------------------------------------------
package ddpi_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CNT_W        = $clog2(CORDIC_STEPS);
	localparam int CW           = 34;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [32:0]   RAD_TO_BAM  = 33'sd683565276;

	localparam logic [1:0] REG_WHEEL_RADIUS = 2'd0;
	localparam logic [1:0] REG_INV_TRACK    = 2'd1;
	localparam logic [1:0] REG_STEP_TIME    = 2'd2;

	typedef struct packed {
		logic        start;
		logic [31:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic                 busy;
		logic signed [CW-1:0] cos_v;
		logic signed [CW-1:0] sin_v;
	} cordic_rsp_t;

	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		logic [31:0] a;
		case (i)
			5'd0:  a = 32'h20000000;
			5'd1:  a = 32'h12E4051E;
			5'd2:  a = 32'h09FB385B;
			5'd3:  a = 32'h051111D4;
			5'd4:  a = 32'h028B0D43;
			5'd5:  a = 32'h0145D7E1;
			5'd6:  a = 32'h00A2F61E;
			5'd7:  a = 32'h00517C55;
			5'd8:  a = 32'h0028BE53;
			5'd9:  a = 32'h00145F2F;
			5'd10: a = 32'h000A2F98;
			5'd11: a = 32'h000517CC;
			5'd12: a = 32'h00028BE6;
			5'd13: a = 32'h000145F3;
			5'd14: a = 32'h0000A2FA;
			5'd15: a = 32'h0000517D;
			5'd16: a = 32'h000028BE;
			5'd17: a = 32'h0000145F;
			5'd18: a = 32'h00000A30;
			5'd19: a = 32'h00000518;
			5'd20: a = 32'h0000028C;
			5'd21: a = 32'h00000146;
			5'd22: a = 32'h000000A3;
			5'd23: a = 32'h00000051;
			5'd24: a = 32'h00000029;
			5'd25: a = 32'h00000014;
			5'd26: a = 32'h0000000A;
			5'd27: a = 32'h00000005;
			5'd28: a = 32'h00000003;
			5'd29: a = 32'h00000001;
			default: a = 32'h00000000;
		endcase
		return a;
	endfunction

	// round half up, then arithmetic shift
	function automatic logic signed [66:0] rnd(input logic signed [66:0] x,
		input logic [4:0] n);
		return (x + (67'sd1 <<< (n - 5'd1))) >>> n;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [66:0] x);
		if (x > 67'sd32767)
			return 16'sh7FFF;
		else if (x < -67'sd32768)
			return 16'sh8000;
		else
			return x[15:0];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [66:0] x);
		if (x > 67'sd8388607)
			return 24'sh7FFFFF;
		else if (x < -67'sd8388608)
			return 24'sh800000;
		else
			return x[23:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [66:0] x);
		if (x > 67'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (x < -67'sd2147483648)
			return 32'sh80000000;
		else
			return x[31:0];
	endfunction

endpackage

// File: src/ddpi_cordic.sv
// ----------------------------------------------------------------------------
// ddpi_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module ddpi_cordic
	import ddpi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cordic_req_t req,
	output cordic_rsp_t rsp
);

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic signed [CW-1:0] x_q, y_q, z_q;
	logic                 flip_q;
	logic                 flip;
	logic [31:0]          ang_t;
	logic signed [CW-1:0] xs, ys, at;

	always_comb begin
		flip  = ((req.angle + 32'h40000000) >> 31) != 32'd0;
		ang_t = flip ? req.angle + 32'h80000000 : req.angle;
		xs    = x_q >>> cnt_q;
		ys    = y_q >>> cnt_q;
		at    = $signed({2'b00, atan_bam(5'(cnt_q))});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(CORDIC_STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= CW'($signed(ang_t));
			flip_q <= flip;
		end else if (busy_q) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign rsp.busy  = busy_q;
	assign rsp.cos_v = flip_q ? -x_q : x_q;
	assign rsp.sin_v = flip_q ? -y_q : y_q;

endmodule

// File: src/diff_drive_pose_integrator.sv
// ----------------------------------------------------------------------------
// diff_drive_pose_integrator
// Differential-drive odometry with trapezoidal pose integration.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) takes one item: kind, left and right wheel
// speed. A tick item gives one result on the output channel (out_valid/
// out_stall): pose, this tick's velocities and the heading quaternion. A clear
// item zeroes pose and previous velocities and gives no result.
// A tick raises out_valid as the sequencer leaves ST_OUT for ST_IDLE, and the
// next item can be taken while out_valid is high; until then a tick holds the
// block: a sequencer drives one shared multiplier through nine products and
// waits on one iterative CORDIC for the heading before and once more for the
// half heading after.
// in_stall is high while a tick is at work. The result sits in an output
// register; if it is still stalled when the next result is ready, the
// sequencer holds in ST_OUT until it is taken. The user must write registers
// through cfg_we/cfg_index/cfg_data only while idle; the block does not
// enforce this. Reset loads register defaults and zero state.
// ----------------------------------------------------------------------------
module diff_drive_pose_integrator
	import ddpi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic signed [15:0] left_wheel_speed,
	input  logic signed [15:0] right_wheel_speed,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] heading,
	output logic signed [23:0] vel_x,
	output logic signed [23:0] vel_y,
	output logic signed [23:0] heading_rate,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIFF, ST_RATE, ST_RATEW, ST_CWAIT, ST_VY, ST_PX, ST_PY,
		ST_HD, ST_DQ, ST_HK, ST_HU, ST_C2, ST_C2W, ST_OUT
	} state_t;

	state_t state_q;

	logic [15:0]        radius_q, inv_tw_q;
	logic [23:0]        dt_q;
	logic signed [31:0] posx_q, posy_q, head_q;
	logic signed [23:0] pvx_q, pvy_q, prate_q;
	logic signed [23:0] vx_q, vy_q, rate_q;
	logic signed [25:0] v_q;
	logic signed [32:0] d_q;
	logic signed [15:0] wl_q, wr_q;
	logic signed [66:0] prod_q;

	logic signed [33:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [16:0] sum_w, dif_w;
	logic signed [66:0] r9, r17, r20, r24, r25, r30;
	logic signed [66:0] nposx, nposy;
	logic               accept, out_free;

	cordic_req_t creq;
	cordic_rsp_t crsp;

	ddpi_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (creq),
		.rsp    (crsp)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		// sum is taken straight from the item while it is being accepted
		sum_w = {right_wheel_speed[15], right_wheel_speed}
			+ {left_wheel_speed[15], left_wheel_speed};
		dif_w = {wr_q[15], wr_q} - {wl_q[15], wl_q};
		r9    = rnd(prod_q, 5'd9);
		r17   = rnd(prod_q, 5'd17);
		r20   = rnd(prod_q, 5'd20);
		r24   = rnd(prod_q, 5'd24);
		r25   = rnd(prod_q, 5'd25);
		r30   = rnd(prod_q, 5'd30);
		nposx = 67'(posx_q) + r25;
		nposy = 67'(posy_q) + r25;
		mul_a = 34'(sum_w);
		mul_b = $signed({17'b0, radius_q});
		unique case (state_q)
			ST_DIFF: begin
				mul_a = 34'(dif_w);
				mul_b = $signed({17'b0, radius_q});
			end
			ST_RATE: begin
				mul_a = prod_q[33:0];
				mul_b = $signed({17'b0, inv_tw_q});
			end
			ST_CWAIT: begin
				mul_a = 34'(v_q);
				mul_b = crsp.cos_v[32:0];
			end
			ST_VY: begin
				mul_a = 34'(v_q);
				mul_b = crsp.sin_v[32:0];
			end
			ST_PX: begin
				mul_a = 34'(vx_q) + 34'(pvx_q);
				mul_b = $signed({9'b0, dt_q});
			end
			ST_PY: begin
				mul_a = 34'(vy_q) + 34'(pvy_q);
				mul_b = $signed({9'b0, dt_q});
			end
			ST_HD: begin
				mul_a = 34'(rate_q) + 34'(prate_q);
				mul_b = $signed({9'b0, dt_q});
			end
			ST_HK: begin
				mul_a = 34'(d_q);
				mul_b = RAD_TO_BAM;
			end
			default: begin
				mul_a = 34'(sum_w);
				mul_b = $signed({17'b0, radius_q});
			end
		endcase
		creq.start = 1'b0;
		creq.angle = head_q;
		if (state_q == ST_IDLE) begin
			creq.start = accept && !kind;
		end else if (state_q == ST_C2) begin
			creq.start = 1'b1;
			creq.angle = head_q >>> 1;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			radius_q  <= 16'd6554;
			inv_tw_q  <= 16'd8192;
			dt_q      <= 24'd167772;
			posx_q    <= '0;
			posy_q    <= '0;
			head_q    <= '0;
			pvx_q     <= '0;
			pvy_q     <= '0;
			prate_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_WHEEL_RADIUS: radius_q <= cfg_data[15:0];
					REG_INV_TRACK:    inv_tw_q <= cfg_data[15:0];
					REG_STEP_TIME:    dt_q     <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == ST_OUT && out_free)
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind) begin
							posx_q  <= '0;
							posy_q  <= '0;
							head_q  <= '0;
							pvx_q   <= '0;
							pvy_q   <= '0;
							prate_q <= '0;
						end else begin
							state_q <= ST_DIFF;
						end
					end
				end
				ST_DIFF: begin
					v_q     <= r9[25:0];
					state_q <= ST_RATE;
				end
				ST_RATE:  state_q <= ST_RATEW;
				ST_RATEW: begin
					rate_q  <= sat24(r20);
					state_q <= ST_CWAIT;
				end
				ST_CWAIT: begin
					if (!crsp.busy)
						state_q <= ST_VY;
				end
				ST_VY: begin
					vx_q    <= sat24(r30);
					state_q <= ST_PX;
				end
				ST_PX: begin
					vy_q    <= sat24(r30);
					state_q <= ST_PY;
				end
				ST_PY: begin
					posx_q  <= sat32(nposx);
					state_q <= ST_HD;
				end
				ST_HD: begin
					posy_q  <= sat32(nposy);
					state_q <= ST_DQ;
				end
				ST_DQ: begin
					d_q     <= r17[32:0];
					state_q <= ST_HK;
				end
				ST_HK: state_q <= ST_HU;
				ST_HU: begin
					head_q  <= head_q + r24[31:0];
					pvx_q   <= vx_q;
					pvy_q   <= vy_q;
					prate_q <= rate_q;
					state_q <= ST_C2;
				end
				ST_C2:  state_q <= ST_C2W;
				ST_C2W: begin
					if (!crsp.busy)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wl_q <= left_wheel_speed;
			wr_q <= right_wheel_speed;
		end
		if (state_q == ST_OUT && out_free) begin
			pos_x        <= posx_q;
			pos_y        <= posy_q;
			heading      <= head_q;
			vel_x        <= vx_q;
			vel_y        <= vy_q;
			heading_rate <= rate_q;
			quat_z       <= sat16(rnd(67'(crsp.sin_v), 5'd15));
			quat_w       <= sat16(rnd(67'(crsp.cos_v), 5'd15));
		end
	end

endmodule

// File: src/ddpi_checker.sv
// ----------------------------------------------------------------------------
// ddpi_checker
// Port-level checks on the pose integrator, bound to the top level.
// ----------------------------------------------------------------------------
module ddpi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        kind,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] pos_x,
	input logic [31:0] heading
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(heading))
		else $error("result changed while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !kind |=> in_stall)
		else $error("tick not held busy");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind && !out_valid |=> !out_valid)
		else $error("clear item gave a result");

	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without tick at work");

endmodule

bind diff_drive_pose_integrator ddpi_checker u_ddpi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.kind      (kind),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.pos_x     (pos_x),
	.heading   (heading)
);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the differential-drive pose integrator. A local
// model predicts pose, velocities and quaternion for every accepted tick
// item. Directed tests cover reset defaults, extreme speeds, clear items,
// register writes and position saturation. Random phases then run under
// several register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top
	import ddpi_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 1000000;
	localparam int SETTLE = 60;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic signed [31:0] px, py, hd;
		logic signed [23:0] vx, vy, hr;
		logic signed [15:0] qz, qw;
	} pose_t;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic in_valid = 0, in_stall, kind = 0;
	logic signed [15:0] left_wheel_speed = '0, right_wheel_speed = '0;
	logic out_valid, out_stall = 0;
	logic signed [31:0] pos_x, pos_y, heading;
	logic signed [23:0] vel_x, vel_y, heading_rate;
	logic signed [15:0] quat_z, quat_w;

	diff_drive_pose_integrator dut (.*);

	always #5 clk = ~clk;

	// model state
	longint m_radius, m_itw, m_dt, m_px, m_py, m_pvx, m_pvy, m_prate;
	logic [31:0] m_head;
	pose_t pending_poses[$];
	int fails = 0, cycles = 0, stall_left = 0;
	bit quiet = 0;

	longint atan_tab[16] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53,
		32'h00145F2F, 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3,
		32'h0000A2FA, 32'h0000517D};

	function automatic longint rnd_shr(longint x, int n);
		return (x + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic longint clamp(longint x, int w);
		longint hi, lo;
		hi = (64'sd1 <<< (w - 1)) - 1;
		lo = -hi - 1;
		return x > hi ? hi : (x < lo ? lo : x);
	endfunction

	task automatic rotate(input logic [31:0] ang, output longint c, output longint s);
		bit flip;
		longint x, y, z, t;
		logic [31:0] a2;
		a2 = ang + 32'h40000000;
		flip = a2[31];
		x = 652032874;
		y = 0;
		if (flip) ang = ang + 32'h80000000;
		z = longint'(signed'(ang));
		for (int i = 0; i < CORDIC_STEPS && i < 16; i++) begin
			if (z >= 0) begin
				t = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_tab[i];
			end else begin
				t = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_tab[i];
			end
			x = t;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic predict_pose(input logic k, input logic signed [15:0] wl,
		input logic signed [15:0] wr);
		longint v, rate, c, s, vx, vy, d;
		logic [31:0] half;
		pose_t p;
		if (k) begin
			m_px = 0; m_py = 0; m_head = 0; m_pvx = 0; m_pvy = 0; m_prate = 0;
			return;
		end
		v = rnd_shr(m_radius * (longint'(wr) + longint'(wl)), 9);
		rate = clamp(rnd_shr(m_radius * (longint'(wr) - longint'(wl)) * m_itw, 20), 24);
		rotate(m_head, c, s);
		vx = clamp(rnd_shr(v * c, 30), 24);
		vy = clamp(rnd_shr(v * s, 30), 24);
		m_px = clamp(m_px + rnd_shr((vx + m_pvx) * m_dt, 25), 32);
		m_py = clamp(m_py + rnd_shr((vy + m_pvy) * m_dt, 25), 32);
		d = rnd_shr((rate + m_prate) * m_dt, 17);
		m_head = m_head + 32'(rnd_shr(d * 683565276, 24));
		m_pvx = vx; m_pvy = vy; m_prate = rate;
		half = 32'(signed'(m_head) >>> 1);
		rotate(half, c, s);
		p.px = 32'(m_px); p.py = 32'(m_py); p.hd = m_head;
		p.vx = 24'(vx); p.vy = 24'(vy); p.hr = 24'(rate);
		p.qz = 16'(clamp(rnd_shr(s, 15), 16));
		p.qw = 16'(clamp(rnd_shr(c, 15), 16));
		pending_poses.push_back(p);
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		fails++;
	endtask

	// result checker and output stall
	always @(posedge clk) begin
		pose_t p;
		cycles <= cycles + 1;
		if (out_valid && !out_stall) begin
			if (pending_poses.size() == 0)
				report("unexpected item", 1, 0);
			else begin
				p = pending_poses.pop_front();
				if (pos_x !== p.px) report("pos_x", pos_x, p.px);
				if (pos_y !== p.py) report("pos_y", pos_y, p.py);
				if (heading !== p.hd) report("heading", heading, p.hd);
				if (vel_x !== p.vx) report("vel_x", vel_x, p.vx);
				if (vel_y !== p.vy) report("vel_y", vel_y, p.vy);
				if (heading_rate !== p.hr) report("heading_rate", heading_rate, p.hr);
				if (quat_z !== p.qz) report("quat_z", quat_z, p.qz);
				if (quat_w !== p.qw) report("quat_w", quat_w, p.qw);
			end
			stall_left = quiet ? 0 : $urandom_range(0, 4);
		end
		if (stall_left > 0) begin
			out_stall <= 1;
			stall_left--;
		end else
			out_stall <= 0;
	end

	always @(posedge clk)
		if (cycles > LIMIT) begin
			$display("Verification failed");
			$finish;
		end

	task automatic send_item(input logic k, input logic signed [15:0] wl,
		input logic signed [15:0] wr);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		kind <= k;
		left_wheel_speed <= wl;
		right_wheel_speed <= wr;
		do @(posedge clk); while (!(in_valid && !in_stall));
		predict_pose(k, wl, wr);
	endtask

	task automatic drain;
		in_valid <= 0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
		drain();
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			REG_WHEEL_RADIUS: m_radius = longint'(val[15:0]);
			REG_INV_TRACK:    m_itw = longint'(val[15:0]);
			REG_STEP_TIME:    m_dt = longint'(val);
			default: ;
		endcase
	endtask

	task automatic test_defaults;
		send_item(0, 16'sd256, 16'sd512);
		send_item(0, 16'sd512, 16'sd256);
		send_item(0, 16'sd0, 16'sd0);
	endtask

	task automatic test_extremes;
		send_item(0, 16'sh7FFF, 16'sh7FFF);
		send_item(0, 16'sh8000, 16'sh8000);
		send_item(0, 16'sh8000, 16'sh7FFF);
		send_item(0, 16'sh7FFF, 16'sh8000);
		send_item(0, 16'shFFFF, 16'sh5555);
		send_item(0, 16'shAAAA, 16'sh0001);
	endtask

	task automatic test_clear;
		send_item(1, 16'sh1234, 16'sh7FFF);
		send_item(0, 16'sd100, 16'sd300);
		send_item(1, 16'shFFFF, 16'sh8000);
		send_item(1, 16'sd0, 16'sd0);
		send_item(0, 16'sd300, 16'sd100);
	endtask

	task automatic test_registers;
		write_reg(REG_UNUSED, 24'hFFFFFF);
		send_item(0, 16'sd900, 16'sd700);
		write_reg(REG_WHEEL_RADIUS, 24'hFFFFFF);
		write_reg(REG_INV_TRACK, 24'hFFFFFF);
		write_reg(REG_STEP_TIME, 24'hFFFFFF);
		send_item(0, 16'sh7FFF, 16'sh8000);
		send_item(0, 16'sh8000, 16'sh7FFF);
		send_item(0, 16'sd4000, 16'sd9000);
		write_reg(REG_WHEEL_RADIUS, 24'd0);
		write_reg(REG_INV_TRACK, 24'd0);
		write_reg(REG_STEP_TIME, 24'd0);
		send_item(0, 16'sh7FFF, 16'sh7FFF);
	endtask

	// full speed straight ahead until the position clamps, then reverse
	task automatic test_saturation;
		write_reg(REG_WHEEL_RADIUS, 24'hFFFF);
		write_reg(REG_INV_TRACK, 24'd8192);
		write_reg(REG_STEP_TIME, 24'hFFFFFF);
		send_item(1, 16'sd0, 16'sd0);
		repeat (270) send_item(0, 16'sh7FFF, 16'sh7FFF);
		repeat (270) send_item(0, 16'sh8000, 16'sh8000);
		send_item(1, 16'sd0, 16'sd0);
	endtask

	task automatic test_random;
		int sel;
		logic signed [15:0] wl, wr;
		for (int phase = 0; phase < 4; phase++) begin
			write_reg(REG_WHEEL_RADIUS, 24'($urandom_range(0, 65535)));
			write_reg(REG_INV_TRACK, 24'($urandom_range(0, 65535)));
			write_reg(REG_STEP_TIME, 24'($urandom_range(0, 24'hFFFFFF)));
			for (int n = 0; n < 300; n++) begin
				quiet = (n % 100) >= 80;
				sel = $urandom_range(0, 99);
				wl = 16'($urandom);
				wr = 16'($urandom);
				if (sel < 30) begin
					wl = $signed(wl) >>> 6;
					wr = wl + ($signed(16'($urandom)) >>> 10);
				end
				send_item(sel >= 96, wl, wr);
			end
			quiet = 0;
		end
	endtask

	initial begin
		m_radius = 6554; m_itw = 8192; m_dt = 167772;
		m_px = 0; m_py = 0; m_head = 0; m_pvx = 0; m_pvy = 0; m_prate = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_defaults();
		test_extremes();
		test_clear();
		test_registers();
		test_saturation();
		test_random();
		drain();
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// File: filelist.f
src/ddpi_pkg.sv
src/ddpi_cordic.sv
src/diff_drive_pose_integrator.sv
src/ddpi_checker.sv
sim/tb_top.sv
